// ----- design/glct_pkg.sv -----
// ----------------------------------------------------------------------------
// Grid line cell tracer package
// Shared types and constants for the tracer front end, job queue and back end.
// ----------------------------------------------------------------------------
package glct_pkg;

  localparam int GRID_SIZE   = 32;
  localparam int COORD_W     = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_LINE = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   command;
    coord_t target_x;
    coord_t target_y;
  } cmd_item_t;

  typedef struct packed {
    coord_t cell_x;
    coord_t cell_y;
    logic   last_cell;
  } cell_item_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  typedef struct packed {
    logic idle;
    logic pop;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_TARGET,
    ST_STEP,
    ST_STEP2
  } back_state_t;

endpackage

// ----- design/glct_front.sv -----
// ----------------------------------------------------------------------------
// Grid line cell tracer front end
// Accepts commands, saturates targets, tracks the pen and queues line jobs.
// ----------------------------------------------------------------------------
module glct_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  glct_pkg::cmd_item_t    cmd,
  input  glct_pkg::queue_status_t q_status,
  output logic                   push,
  output glct_pkg::job_t         push_job
);

  localparam glct_pkg::coord_t COORD_MAX = glct_pkg::COORD_W'(glct_pkg::GRID_SIZE - 1);

  glct_pkg::coord_t pen_x;
  glct_pkg::coord_t pen_y;
  glct_pkg::coord_t tx;
  glct_pkg::coord_t ty;
  logic             accept;

  assign cmd_stall = q_status.full;
  assign accept    = cmd_valid && !cmd_stall;
  assign tx        = (cmd.target_x > COORD_MAX) ? COORD_MAX : cmd.target_x;
  assign ty        = (cmd.target_y > COORD_MAX) ? COORD_MAX : cmd.target_y;

  assign push        = accept && (cmd.command == glct_pkg::CMD_LINE);
  assign push_job.x0 = pen_x;
  assign push_job.y0 = pen_y;
  assign push_job.x1 = tx;
  assign push_job.y1 = ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
    end else if (accept) begin
      pen_x <= tx;
      pen_y <= ty;
    end
  end

endmodule

// ----- design/glct_queue.sv -----
// ----------------------------------------------------------------------------
// Grid line cell tracer job queue
// Short first-in first-out buffer of line jobs between front and back end.
// ----------------------------------------------------------------------------
module glct_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  glct_pkg::job_t          push_job,
  input  logic                    pop,
  output glct_pkg::job_t          head_job,
  output glct_pkg::queue_status_t status
);

  glct_pkg::job_t                    entries [glct_pkg::QUEUE_DEPTH];
  logic [glct_pkg::QPTR_W-1:0]       wr_ptr;
  logic [glct_pkg::QPTR_W-1:0]       rd_ptr;
  logic [glct_pkg::QCNT_W-1:0]       count;
  logic                              do_push;
  logic                              do_pop;

  localparam logic [glct_pkg::QCNT_W-1:0] DEPTH_CNT = glct_pkg::QCNT_W'(glct_pkg::QUEUE_DEPTH);
  localparam logic [glct_pkg::QPTR_W-1:0] LAST_PTR  = glct_pkg::QPTR_W'(glct_pkg::QUEUE_DEPTH - 1);

  assign status.full  = (count == DEPTH_CNT);
  assign status.empty = (count == '0);
  assign status.count = count;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/glct_back.sv -----
// ----------------------------------------------------------------------------
// Grid line cell tracer back end
// Walks one line job along its major axis and emits the touched cells.
// ----------------------------------------------------------------------------
module glct_back (
  input  logic                    clk,
  input  logic                    rst,
  input  glct_pkg::job_t          head_job,
  input  glct_pkg::queue_status_t q_status,
  output glct_pkg::back_status_t  status,
  output logic                    cell_valid,
  input  logic                    cell_stall,
  output glct_pkg::cell_item_t    grid_cell
);

  glct_pkg::back_state_t state;
  glct_pkg::back_state_t state_next;

  glct_pkg::job_t   job;
  logic             horiz;
  logic             adv_up;
  glct_pkg::coord_t maj;
  glct_pkg::coord_t me;
  logic signed [5:0] s;
  logic [5:0]       den;
  glct_pkg::coord_t f;
  logic [5:0]       r;

  logic signed [5:0] dx_c;
  logic signed [5:0] dy_c;
  logic [4:0]       adx_c;
  logic [4:0]       ady_c;
  logic             horiz_c;
  logic [4:0]       d_c;
  logic signed [5:0] s_c;
  glct_pkg::coord_t ms_c;
  glct_pkg::coord_t me_c;
  glct_pkg::coord_t m0_c;
  logic [5:0]       den_c;
  logic signed [7:0] t_c;
  glct_pkg::coord_t f_c;
  logic [5:0]       r_c;
  logic             same_c;

  logic signed [7:0] rsum;
  logic signed [7:0] rnorm;
  glct_pkg::coord_t fn;
  logic [5:0]       rn;
  logic             wrap;
  logic             cur_v;
  logic             s_pos;
  glct_pkg::coord_t cell1;
  logic             second;
  glct_pkg::coord_t maj_n;
  logic             end_step;

  logic             load;
  logic             emit;
  glct_pkg::cell_item_t emit_item;
  logic             pop;
  logic             setup_en;
  logic             adv_en;
  logic             frac_en;

  function automatic glct_pkg::cell_item_t axis_cell(input logic h,
                                                     input glct_pkg::coord_t major,
                                                     input glct_pkg::coord_t minor,
                                                     input logic last);
    glct_pkg::cell_item_t c;
    c.cell_x    = h ? major : minor;
    c.cell_y    = h ? minor : major;
    c.last_cell = last;
    return c;
  endfunction

  always_comb begin
    dx_c    = $signed({1'b0, job.x1}) - $signed({1'b0, job.x0});
    dy_c    = $signed({1'b0, job.y1}) - $signed({1'b0, job.y0});
    adx_c   = dx_c[5] ? 5'(-dx_c) : dx_c[4:0];
    ady_c   = dy_c[5] ? 5'(-dy_c) : dy_c[4:0];
    horiz_c = (adx_c >= ady_c);
    d_c     = horiz_c ? adx_c : ady_c;
    s_c     = horiz_c ? dy_c : dx_c;
    ms_c    = horiz_c ? job.x0 : job.y0;
    me_c    = horiz_c ? job.x1 : job.y1;
    m0_c    = horiz_c ? job.y0 : job.x0;
    den_c   = {d_c, 1'b0};
    t_c     = $signed({3'b000, d_c}) + 8'(s_c);
    same_c  = (job.x0 == job.x1) && (job.y0 == job.y1);
    if (t_c == $signed({2'b00, den_c})) begin
      f_c = m0_c + 1'b1;
      r_c = '0;
    end else begin
      f_c = m0_c;
      r_c = t_c[5:0];
    end
  end

  always_comb begin
    rsum  = $signed({2'b00, r}) + $signed({s[5], s, 1'b0});
    rnorm = rsum;
    fn    = f;
    wrap  = 1'b0;
    if (rsum >= $signed({2'b00, den})) begin
      rnorm = rsum - $signed({2'b00, den});
      fn    = f + 1'b1;
      wrap  = 1'b1;
    end else if (rsum < 0) begin
      rnorm = rsum + $signed({2'b00, den});
      fn    = f - 1'b1;
      wrap  = 1'b1;
    end
    rn       = rnorm[5:0];
    cur_v    = (r == '0);
    s_pos    = !s[5] && (s != '0);
    cell1    = (cur_v && !s_pos) ? f - 1'b1 : f;
    second   = wrap && !cur_v && (rn != '0);
    maj_n    = adv_up ? maj + 1'b1 : maj - 1'b1;
    end_step = (maj_n == me);
  end

  assign load = !cell_valid || !cell_stall;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_item  = axis_cell(horiz, maj, f, 1'b0);
    pop        = 1'b0;
    setup_en   = 1'b0;
    adv_en     = 1'b0;
    frac_en    = 1'b0;
    unique case (state)
      glct_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = glct_pkg::ST_START;
        end
      end
      glct_pkg::ST_START: begin
        if (load) begin
          emit                = 1'b1;
          emit_item.cell_x    = job.x0;
          emit_item.cell_y    = job.y0;
          emit_item.last_cell = same_c;
          setup_en            = 1'b1;
          state_next          = same_c ? glct_pkg::ST_IDLE : glct_pkg::ST_TARGET;
        end
      end
      glct_pkg::ST_TARGET: begin
        if (load) begin
          emit                = 1'b1;
          emit_item.cell_x    = job.x1;
          emit_item.cell_y    = job.y1;
          emit_item.last_cell = end_step;
          adv_en              = 1'b1;
          state_next          = end_step ? glct_pkg::ST_IDLE : glct_pkg::ST_STEP;
        end
      end
      glct_pkg::ST_STEP: begin
        if (load) begin
          emit      = 1'b1;
          emit_item = axis_cell(horiz, maj, cell1, !second && end_step);
          frac_en   = 1'b1;
          if (second) begin
            state_next = glct_pkg::ST_STEP2;
          end else begin
            adv_en     = 1'b1;
            state_next = end_step ? glct_pkg::ST_IDLE : glct_pkg::ST_STEP;
          end
        end
      end
      glct_pkg::ST_STEP2: begin
        if (load) begin
          emit       = 1'b1;
          emit_item  = axis_cell(horiz, maj, f, end_step);
          adv_en     = 1'b1;
          state_next = end_step ? glct_pkg::ST_IDLE : glct_pkg::ST_STEP;
        end
      end
      default: begin
        state_next = glct_pkg::ST_IDLE;
      end
    endcase
  end

  assign status.idle = (state == glct_pkg::ST_IDLE);
  assign status.pop  = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= glct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head_job;
    end
    if (setup_en) begin
      horiz  <= horiz_c;
      adv_up <= (me_c > ms_c);
      maj    <= ms_c;
      me     <= me_c;
      s      <= s_c;
      den    <= den_c;
      f      <= f_c;
      r      <= r_c;
    end
    if (frac_en) begin
      f <= fn;
      r <= rn;
    end
    if (adv_en) begin
      maj <= maj_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (load) begin
      cell_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      grid_cell <= emit_item;
    end
  end

endmodule

// ----- design/grid_line_cell_tracer.sv -----
// ----------------------------------------------------------------------------
// Grid line cell tracer
// Pen on a square grid that traces the cells touched by each drawn line.
// ----------------------------------------------------------------------------
// A move command sets the pen and produces no cells; it is taken whenever the
// two-entry job queue has room. A line command is queued and then traced by
// the back end, which emits one cell per cycle into the output register while
// cell_stall is low: the start cell, the target cell, and one or two cells for
// each of the D-1 inner columns or rows along the major axis, D being the
// major-axis distance. A line therefore occupies the back end for a fetch from
// the queue plus 2 to 2*D cells, a length set by the sequential walk along the
// major axis. A line to the pen's own position emits only the start cell. The
// final cell of each line carries last_cell.
module grid_line_cell_tracer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  glct_pkg::cmd_item_t  cmd,
  output logic                 cell_valid,
  input  logic                 cell_stall,
  output glct_pkg::cell_item_t grid_cell
);

  logic                    push;
  glct_pkg::job_t          push_job;
  glct_pkg::job_t          head_job;
  glct_pkg::queue_status_t q_status;
  glct_pkg::back_status_t  b_status;

  glct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  glct_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (b_status.pop),
    .head_job(head_job),
    .status  (q_status)
  );

  glct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (head_job),
    .q_status  (q_status),
    .status    (b_status),
    .cell_valid(cell_valid),
    .cell_stall(cell_stall),
    .grid_cell (grid_cell)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= glct_pkg::QCNT_W'(glct_pkg::QUEUE_DEPTH))
    else $error("job queue count exceeds its depth");

  a_move_no_job: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd.command == glct_pkg::CMD_MOVE) |-> !push)
    else $error("move command queued a line job");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    b_status.pop |-> !q_status.empty)
    else $error("back end fetched from an empty queue");

  a_fetch_when_ready: assert property (@(posedge clk) disable iff (rst)
    b_status.idle && !q_status.empty |=> !b_status.idle)
    else $error("back end idle while a job waits");
`endif

endmodule
